### rtl/core/dmcs_pkg.sv
// Shared types, codes and reset values for the door motor current supervisor.
`timescale 1ns / 1ps

package dmcs_pkg;

    localparam int DEF_SAMPLE_BITS = 12;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_RUN_CURRENT     = 3'd0;
    localparam logic [2:0] REG_ZERO_LEVEL      = 3'd1;
    localparam logic [2:0] REG_OVERLOAD_MARGIN = 3'd2;
    localparam logic [2:0] REG_CLOSE_DRIFT     = 3'd3;
    localparam logic [2:0] REG_OPEN_DRIFT      = 3'd4;
    localparam logic [2:0] REG_FAULT_COUNT     = 3'd5;
    localparam logic [2:0] REG_STOPPED_COUNT   = 3'd6;
    localparam logic [2:0] REG_SETTLE_SAMPLES  = 3'd7;

    localparam logic [11:0] RST_RUN_CURRENT     = 12'd0;
    localparam logic [11:0] RST_ZERO_LEVEL      = 12'd0;
    localparam logic [12:0] RST_OVERLOAD_MARGIN = 13'd4095;
    localparam logic [11:0] RST_CLOSE_DRIFT     = 12'd10;
    localparam logic [11:0] RST_OPEN_DRIFT      = 12'd10;
    localparam logic [15:0] RST_FAULT_COUNT     = 16'd10;
    localparam logic [15:0] RST_STOPPED_COUNT   = 16'd10;
    localparam logic [15:0] RST_SETTLE_SAMPLES  = 16'd50;

    // Command codes
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_OPEN   = 2'd2;

    // Drive codes
    localparam logic [1:0] DRIVE_OFF   = 2'd0;
    localparam logic [1:0] DRIVE_OPEN  = 2'd1;
    localparam logic [1:0] DRIVE_CLOSE = 2'd2;

    // Event codes
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_CLOSED_OK = 2'd1;
    localparam logic [1:0] EV_FAULT     = 2'd2;
    localparam logic [1:0] EV_OPENED    = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CLOSING = 2'd1,
        MODE_OPENING = 2'd2
    } mode_t;

    function automatic logic [15:0] cnt_up(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic logic [15:0] cnt_down(input logic [15:0] c);
        return (c == 16'd0) ? c : c - 16'd1;
    endfunction

endpackage

### rtl/core/door_motor_current_supervisor.sv
// Door motor current supervisor: move sequencing, current checks and config registers.
`timescale 1ns / 1ps

// Usage:
//   Input channel (s_valid/s_ready): s_cmd selects a sample tick, start close or
//   start open; s_current_sample carries the converter reading for a tick.
//   Result channel (m_valid/m_ready): one result per input transfer with the
//   motor drive, an event code (closed ok, overload fault, opened), the door
//   open/closed flags and busy.
//   Config: APB-style write/read port, register i at byte address 4*i. Write
//   only while no transfer is pending.
//   Latency: the result of a transfer is valid in the cycle after it.
//   Throughput: one transfer per cycle while no result is stalled; all checks and
//   counter updates are combinational between acceptance and the result register.
//   Stall: while a result waits for m_ready, s_ready is low, so the state and
//   the shown result hold until the result transfer completes.
//   Reset: synchronous, active low; the motor goes idle with drive off, the
//   counters and flags clear, and registers take their default values.
module door_motor_current_supervisor
    import dmcs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [SAMPLE_BITS-1:0] s_current_sample,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_drive,
    output logic [1:0]             m_event_res,
    output logic                   m_is_open,
    output logic                   m_is_closed,
    output logic                   m_busy_res,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int UW    = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam int EXC_W = UW + 1;
    localparam int CMP_W = (EXC_W > 14) ? EXC_W : 14;

    // Configuration registers
    logic [11:0] run_current_reg;
    logic [11:0] zero_level_reg;
    logic [12:0] overload_margin_reg;
    logic [11:0] close_drift_reg;
    logic [11:0] open_drift_reg;
    logic [15:0] fault_count_reg;
    logic [15:0] stopped_count_reg;
    logic [15:0] settle_samples_reg;

    // Supervisor state
    mode_t                    mode_reg, mode_next;
    logic [15:0]              settle_left_reg, settle_left_next;
    logic [15:0]              ov_cnt_reg, ov_cnt_next;
    logic [15:0]              stop_cnt_reg, stop_cnt_next;
    logic signed [EXC_W-1:0]  prev_exc_reg, prev_exc_next;
    logic                     open_flag_reg, open_flag_next;
    logic                     closed_flag_reg, closed_flag_next;
    logic [1:0]               event_reg, event_next;
    logic                     m_valid_reg;

    logic                     s_accept;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    logic [UW-1:0]            samp_u;
    logic [UW-1:0]            run_u;
    logic signed [EXC_W-1:0]  exc;
    logic signed [CMP_W-1:0]  exc_c;
    logic signed [CMP_W-1:0]  prev_c;
    logic signed [CMP_W-1:0]  ov_c;
    logic signed [CMP_W-1:0]  lim_close_c;
    logic signed [CMP_W-1:0]  lim_open_c;
    logic [12:0]              lim_close_sum;
    logic [12:0]              lim_open_sum;
    logic                     is_over;
    logic                     is_low_close;
    logic                     is_low_open;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[4:2];

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_current_reg     <= RST_RUN_CURRENT;
            zero_level_reg      <= RST_ZERO_LEVEL;
            overload_margin_reg <= RST_OVERLOAD_MARGIN;
            close_drift_reg     <= RST_CLOSE_DRIFT;
            open_drift_reg      <= RST_OPEN_DRIFT;
            fault_count_reg     <= RST_FAULT_COUNT;
            stopped_count_reg   <= RST_STOPPED_COUNT;
            settle_samples_reg  <= RST_SETTLE_SAMPLES;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RUN_CURRENT:     run_current_reg     <= pwdata[11:0];
                REG_ZERO_LEVEL:      zero_level_reg      <= pwdata[11:0];
                REG_OVERLOAD_MARGIN: overload_margin_reg <= pwdata[12:0];
                REG_CLOSE_DRIFT:     close_drift_reg     <= pwdata[11:0];
                REG_OPEN_DRIFT:      open_drift_reg      <= pwdata[11:0];
                REG_FAULT_COUNT:     fault_count_reg     <= pwdata[15:0];
                REG_STOPPED_COUNT:   stopped_count_reg   <= pwdata[15:0];
                REG_SETTLE_SAMPLES:  settle_samples_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RUN_CURRENT:     prdata = CFG_DATA_W'(run_current_reg);
            REG_ZERO_LEVEL:      prdata = CFG_DATA_W'(zero_level_reg);
            REG_OVERLOAD_MARGIN: prdata = CFG_DATA_W'(overload_margin_reg);
            REG_CLOSE_DRIFT:     prdata = CFG_DATA_W'(close_drift_reg);
            REG_OPEN_DRIFT:      prdata = CFG_DATA_W'(open_drift_reg);
            REG_FAULT_COUNT:     prdata = CFG_DATA_W'(fault_count_reg);
            REG_STOPPED_COUNT:   prdata = CFG_DATA_W'(stopped_count_reg);
            REG_SETTLE_SAMPLES:  prdata = CFG_DATA_W'(settle_samples_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- current checks ----------------
    assign samp_u = UW'(s_current_sample);
    assign run_u  = UW'(run_current_reg);
    assign exc    = $signed({1'b0, samp_u}) - $signed({1'b0, run_u});

    assign lim_close_sum = {1'b0, zero_level_reg} + {1'b0, close_drift_reg};
    assign lim_open_sum  = {1'b0, zero_level_reg} + {1'b0, open_drift_reg};

    // Limits are non-negative, so zero-extend before the signed compare
    assign exc_c       = CMP_W'(exc);
    assign prev_c      = CMP_W'(prev_exc_reg);
    assign ov_c        = $signed(CMP_W'(overload_margin_reg));
    assign lim_close_c = $signed(CMP_W'(lim_close_sum));
    assign lim_open_c  = $signed(CMP_W'(lim_open_sum));

    assign is_over      = (exc_c > ov_c) && (prev_c > ov_c);
    assign is_low_close = (exc_c < lim_close_c) && (prev_c < lim_close_c);
    assign is_low_open  = (exc_c < lim_open_c) && (prev_c < lim_open_c);

    // ---------------- next state ----------------
    always_comb begin
        mode_next        = mode_reg;
        settle_left_next = settle_left_reg;
        ov_cnt_next      = ov_cnt_reg;
        stop_cnt_next    = stop_cnt_reg;
        prev_exc_next    = prev_exc_reg;
        open_flag_next   = open_flag_reg;
        closed_flag_next = closed_flag_reg;
        event_next       = EV_NONE;

        case (s_cmd)
            CMD_CLOSE, CMD_OPEN: begin
                if (mode_reg == MODE_IDLE) begin
                    mode_next        = (s_cmd == CMD_CLOSE) ? MODE_CLOSING : MODE_OPENING;
                    settle_left_next = settle_samples_reg;
                    ov_cnt_next      = '0;
                    stop_cnt_next    = '0;
                    prev_exc_next    = '0;
                end
            end
            CMD_SAMPLE: begin
                if (mode_reg != MODE_IDLE) begin
                    if (settle_left_reg != 16'd0) begin
                        settle_left_next = settle_left_reg - 16'd1;
                    end else begin
                        prev_exc_next = exc;
                        case (mode_reg)
                            MODE_CLOSING: begin
                                if (is_over) begin
                                    ov_cnt_next   = cnt_up(ov_cnt_reg);
                                    stop_cnt_next = cnt_down(stop_cnt_reg);
                                end else if (is_low_close) begin
                                    ov_cnt_next   = cnt_down(ov_cnt_reg);
                                    stop_cnt_next = cnt_up(stop_cnt_reg);
                                end else begin
                                    ov_cnt_next   = cnt_down(ov_cnt_reg);
                                    stop_cnt_next = cnt_down(stop_cnt_reg);
                                end
                                // fault wins over a simultaneous stop
                                if (ov_cnt_next >= fault_count_reg) begin
                                    event_next     = EV_FAULT;
                                    open_flag_next = 1'b0;
                                    mode_next      = MODE_IDLE;
                                end else if (stop_cnt_next >= stopped_count_reg) begin
                                    event_next       = EV_CLOSED_OK;
                                    closed_flag_next = 1'b1;
                                    open_flag_next   = 1'b0;
                                    mode_next        = MODE_IDLE;
                                end
                            end
                            MODE_OPENING: begin
                                stop_cnt_next = is_low_open ? cnt_up(stop_cnt_reg)
                                                            : cnt_down(stop_cnt_reg);
                                if (stop_cnt_next >= stopped_count_reg) begin
                                    event_next       = EV_OPENED;
                                    open_flag_next   = 1'b1;
                                    closed_flag_next = 1'b0;
                                    mode_next        = MODE_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    // State only moves on an input transfer, which cannot happen while a
    // result is stalled, so the result fields can be read from the state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            settle_left_reg <= '0;
            ov_cnt_reg      <= '0;
            stop_cnt_reg    <= '0;
            prev_exc_reg    <= '0;
            open_flag_reg   <= 1'b0;
            closed_flag_reg <= 1'b0;
            event_reg       <= EV_NONE;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg        <= mode_next;
                settle_left_reg <= settle_left_next;
                ov_cnt_reg      <= ov_cnt_next;
                stop_cnt_reg    <= stop_cnt_next;
                prev_exc_reg    <= prev_exc_next;
                open_flag_reg   <= open_flag_next;
                closed_flag_reg <= closed_flag_next;
                event_reg       <= event_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_CLOSING: m_drive = DRIVE_CLOSE;
            MODE_OPENING: m_drive = DRIVE_OPEN;
            default:      m_drive = DRIVE_OFF;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_event_res = event_reg;
    assign m_is_open   = open_flag_reg;
    assign m_is_closed = closed_flag_reg;
    assign m_busy_res  = (mode_reg != MODE_IDLE);

    // ---------------- assertions ----------------
    a_event_ends_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res != EV_NONE)) |-> (!m_busy_res && (m_drive == DRIVE_OFF)))
        else $error("event reported while a move is still in progress");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(open_flag_reg && closed_flag_reg))
        else $error("door reported both open and closed");

    a_start_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_cmd == CMD_CLOSE) && (mode_reg == MODE_IDLE))
        |=> ((mode_reg == MODE_CLOSING) && (ov_cnt_reg == 16'd0) && (stop_cnt_reg == 16'd0)))
        else $error("close command from idle did not start a clean close");

    a_busy_ignores_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (mode_reg != MODE_IDLE) && ((s_cmd == CMD_CLOSE) || (s_cmd == CMD_OPEN)))
        |=> ((mode_reg == $past(mode_reg)) && (settle_left_reg == $past(settle_left_reg))))
        else $error("command changed a move in progress");

endmodule
